@@ src/gdds_pkg.sv @@
package gdds_pkg;

	// Days from 0000-03-01 to 1970-01-01, and days in a 400-year era
	localparam int unsigned DN_SHIFT = 719468;
	localparam int unsigned ERA_DAYS = 146097;

	// Valid span of shifted day numbers: 0000-01-01 .. 9999-12-31
	localparam logic signed [23:0] DN_LO = -24'sd719528;
	localparam logic signed [23:0] DN_HI = 24'sd2932896;

	// Reciprocals for quotient estimates. The first three are rounded down, so the
	// quotient is exact or one low. 2^24 / 365 is rounded up, but its error stays far
	// below the 1/365 step, so that quotient comes out exact.
	localparam logic [9:0]  RCP_25   = 10'd655;    // 2^14 / 25
	localparam logic [14:0] RCP_ERA  = 15'd29398;  // 2^32 / 146097
	localparam logic [9:0]  RCP_1460 = 10'd718;    // 2^20 / 1460
	localparam logic [15:0] RCP_365  = 16'd45965;  // 2^24 / 365

	// Day of a March-based year on which each month starts, indexed by month 0..15.
	// Month 0 wraps to December, months 13..15 run on into the next year.
	localparam logic [8:0] MONTH_OFFSET [16] = '{
		9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
		9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
	};

	// Original request fields, carried to the output for pass-through
	typedef struct packed {
		logic        present;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} pass_t;

	// Results known early and carried along
	typedef struct packed {
		logic signed [23:0] dn;
		logic [2:0]         wd;
		logic               oor;
	} res_t;

	// March-based month index to calendar month
	function automatic logic [3:0] mp_to_month(input logic [3:0] mp);
		logic [3:0] m;
		m = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
		return m;
	endfunction

	// x mod 7, using 8 == 1 (mod 7) on octal digits
	function automatic logic [2:0] mod7_23(input logic [22:0] x);
		logic [23:0] xp;
		logic [5:0]  s;
		logic [3:0]  f;
		logic [2:0]  g;
		xp = {1'b0, x};
		s  = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 6'(xp[3*i +: 3]);
		end
		f = 4'(s[5:3]) + 4'(s[2:0]);
		g = f[2:0] + 3'(f[3]);
		return (g == 3'd7) ? 3'd0 : g;
	endfunction

endpackage

@@ src/gregorian_date_day_shift.sv @@
// A request passes through 14 register stages, the last one the output register.
// Throughput: one request per cycle while out_stall is low; stages
// hold in place under stall and empty stages fill up behind a stalled output.
// Reset (arst_n low, asynchronous) clears all stage valid bits; payload
// registers are not reset.
module gregorian_date_day_shift (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               date_present,
	input  logic [13:0]        year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	input  logic signed [20:0] day_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               present_out,
	output logic [13:0]        out_year,
	output logic [3:0]         out_month,
	output logic [4:0]         out_day,
	output logic signed [22:0] epoch_day,
	output logic [2:0]         weekday,
	output logic               out_of_range
);

	// ------------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its successor loads.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	logic en_s8, en_s9, en_s10, en_s11, en_s12, en_s13, en_s14;

	assign en_s14 = !v_s14 || !out_stall;
	assign en_s13 = !v_s13 || en_s14;
	assign en_s12 = !v_s12 || en_s13;
	assign en_s11 = !v_s11 || en_s12;
	assign en_s10 = !v_s10 || en_s11;
	assign en_s9  = !v_s9  || en_s10;
	assign en_s8  = !v_s8  || en_s9;
	assign en_s7  = !v_s7  || en_s8;
	assign en_s6  = !v_s6  || en_s7;
	assign en_s5  = !v_s5  || en_s6;
	assign en_s4  = !v_s4  || en_s5;
	assign en_s3  = !v_s3  || en_s4;
	assign en_s2  = !v_s2  || en_s3;
	assign en_s1  = !v_s1  || en_s2;

	assign in_stall  = !en_s1;
	assign out_valid = v_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= in_valid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= v_s2;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= v_s4;
			if (en_s6)  v_s6  <= v_s5;
			if (en_s7)  v_s7  <= v_s6;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
			if (en_s13) v_s13 <= v_s12;
			if (en_s14) v_s14 <= v_s13;
		end
	end

	// ------------------------------------------------------------------
	// Date to day number.
	// Y is the March-based year plus one era (400), so it never goes
	// negative; the era is taken back out in the final offset.
	// ------------------------------------------------------------------
	gdds_pkg::pass_t    pass_s1;
	logic [14:0]        y_s1;
	logic [8:0]         moff_s1;
	logic [4:0]         day_s1;
	logic signed [20:0] delta_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pass_s1.present <= date_present;
			pass_s1.year    <= year;
			pass_s1.month   <= month;
			pass_s1.day     <= day;
			y_s1            <= {1'b0, year} + 15'd400 - 15'(month <= 4'd2);
			moff_s1         <= gdds_pkg::MONTH_OFFSET[month];
			day_s1          <= day;
			delta_s1        <= day_offset;
		end
	end

	// Stage 2: 365*Y + Y/4 + month start + day, and an estimate of Y/100
	gdds_pkg::pass_t    pass_s2;
	logic [22:0]        base_s2;
	logic [12:0]        qd_s2;
	logic [7:0]         q25_s2;
	logic signed [20:0] delta_s2;
	logic [12:0]        qd_c;
	logic [22:0]        p25_c;

	assign qd_c  = y_s1[14:2];
	assign p25_c = 23'(qd_c) * 23'(gdds_pkg::RCP_25);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pass_s2  <= pass_s1;
			base_s2  <= 23'(y_s1) * 23'd365 + 23'(qd_c) + 23'(moff_s1) + 23'(day_s1);
			qd_s2    <= qd_c;
			q25_s2   <= p25_c[21:14];
			delta_s2 <= delta_s1;
		end
	end

	// Stage 3: correct Y/100 (estimate is exact or one low)
	gdds_pkg::pass_t    pass_s3;
	logic [22:0]        base_s3;
	logic [7:0]         y100_s3;
	logic signed [20:0] delta_s3;
	logic [12:0]        r25_c;

	assign r25_c = qd_s2 - 13'(q25_s2) * 13'd25;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pass_s3  <= pass_s2;
			base_s3  <= base_s2;
			y100_s3  <= q25_s2 + 8'(r25_c >= 13'd25);
			delta_s3 <= delta_s2;
		end
	end

	// Stage 4: shifted day number, and w = day number + shift + one era,
	// which is non-negative over the whole valid span
	gdds_pkg::pass_t    pass_s4;
	logic signed [23:0] dn_s4;
	logic [21:0]        w_s4;
	logic signed [24:0] sum_dn_c;
	logic signed [24:0] sum_w_c;

	// base counts the day itself, hence the extra one in the offset
	assign sum_dn_c = $signed({2'b00, base_s3}) - $signed({17'd0, y100_s3})
		+ $signed({19'd0, y100_s3[7:2]}) + $signed(25'(delta_s3))
		- $signed(25'(gdds_pkg::DN_SHIFT + gdds_pkg::ERA_DAYS + 1));
	assign sum_w_c = $signed({2'b00, base_s3}) - $signed({17'd0, y100_s3})
		+ $signed({19'd0, y100_s3[7:2]}) + $signed(25'(delta_s3))
		- 25'sd1;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			pass_s4 <= pass_s3;
			dn_s4   <= sum_dn_c[23:0];
			w_s4    <= sum_w_c[21:0];
		end
	end

	// ------------------------------------------------------------------
	// Day number back to a date. Outside the valid span w is garbage,
	// but then the computed date is never shown.
	// ------------------------------------------------------------------
	// Stage 5: range check, weekday, era estimate
	gdds_pkg::pass_t pass_s5;
	gdds_pkg::res_t  res_s5;
	logic [21:0]     w_s5;
	logic [4:0]      era_s5;
	logic [36:0]     pera_c;

	assign pera_c = 37'(w_s4) * 37'(gdds_pkg::RCP_ERA);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			pass_s5    <= pass_s4;
			res_s5.dn  <= dn_s4;
			res_s5.oor <= (dn_s4 < gdds_pkg::DN_LO) || (dn_s4 > gdds_pkg::DN_HI);
			// dn + 4 == w + 3 (mod 7)
			res_s5.wd  <= gdds_pkg::mod7_23(23'(w_s4) + 23'd3);
			w_s5       <= w_s4;
			era_s5     <= pera_c[36:32];
		end
	end

	// Stage 6: day of era, before correction
	gdds_pkg::pass_t pass_s6;
	gdds_pkg::res_t  res_s6;
	logic [4:0]      era_s6;
	logic [18:0]     doe_raw_s6;
	logic [21:0]     doe_c;

	assign doe_c = w_s5 - 22'(era_s5) * 22'(gdds_pkg::ERA_DAYS);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pass_s6    <= pass_s5;
			res_s6     <= res_s5;
			era_s6     <= era_s5;
			doe_raw_s6 <= doe_c[18:0];
		end
	end

	// Stage 7: correct era and day of era
	gdds_pkg::pass_t pass_s7;
	gdds_pkg::res_t  res_s7;
	logic [4:0]      era_s7;
	logic [17:0]     doe_s7;
	logic            era_fix_c;
	logic [18:0]     doe_fix_c;

	assign era_fix_c = doe_raw_s6 >= 19'(gdds_pkg::ERA_DAYS);
	assign doe_fix_c = era_fix_c ? (doe_raw_s6 - 19'(gdds_pkg::ERA_DAYS)) : doe_raw_s6;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			pass_s7 <= pass_s6;
			res_s7  <= res_s6;
			era_s7  <= era_s6 + 5'(era_fix_c);
			doe_s7  <= doe_fix_c[17:0];
		end
	end

	// Stage 8: doe/1460 estimate, doe/36524 and doe/146096 by compares
	gdds_pkg::pass_t pass_s8;
	gdds_pkg::res_t  res_s8;
	logic [4:0]      era_s8;
	logic [17:0]     doe_s8;
	logic [6:0]      a_s8;
	logic [2:0]      b_s8;
	logic            c_s8;
	logic [27:0]     pa_c;

	assign pa_c = 28'(doe_s7) * 28'(gdds_pkg::RCP_1460);

	always_ff @(posedge clk) begin
		if (en_s8) begin
			pass_s8 <= pass_s7;
			res_s8  <= res_s7;
			era_s8  <= era_s7;
			doe_s8  <= doe_s7;
			a_s8    <= pa_c[26:20];
			b_s8    <= 3'(doe_s7 >= 18'd36524) + 3'(doe_s7 >= 18'd73048)
				+ 3'(doe_s7 >= 18'd109572) + 3'(doe_s7 >= 18'd146096);
			c_s8    <= doe_s7 == 18'd146096;
		end
	end

	// Stage 9: fix doe/1460, then the 365-day-year count numerator
	gdds_pkg::pass_t pass_s9;
	gdds_pkg::res_t  res_s9;
	logic [4:0]      era_s9;
	logic [17:0]     doe_s9;
	logic [17:0]     t_s9;
	logic [17:0]     ra_c;
	logic            a_fix_c;

	assign ra_c    = doe_s8 - 18'(a_s8) * 18'd1460;
	assign a_fix_c = ra_c >= 18'd1460;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			pass_s9 <= pass_s8;
			res_s9  <= res_s8;
			era_s9  <= era_s8;
			doe_s9  <= doe_s8;
			t_s9    <= doe_s8 - 18'(a_s8) - 18'(a_fix_c) + 18'(b_s8) - 18'(c_s8);
		end
	end

	// Stage 10: year of era estimate, t/365
	gdds_pkg::pass_t pass_s10;
	gdds_pkg::res_t  res_s10;
	logic [4:0]      era_s10;
	logic [17:0]     doe_s10;
	logic [17:0]     t_s10;
	logic [8:0]      yq_s10;
	logic [33:0]     py_c;

	assign py_c = 34'(t_s9) * 34'(gdds_pkg::RCP_365);

	always_ff @(posedge clk) begin
		if (en_s10) begin
			pass_s10 <= pass_s9;
			res_s10  <= res_s9;
			era_s10  <= era_s9;
			doe_s10  <= doe_s9;
			t_s10    <= t_s9;
			yq_s10   <= py_c[32:24];
		end
	end

	// Stage 11: corrected year of era
	gdds_pkg::pass_t pass_s11;
	gdds_pkg::res_t  res_s11;
	logic [4:0]      era_s11;
	logic [17:0]     doe_s11;
	logic [8:0]      yoe_s11;
	logic [17:0]     ry_c;

	assign ry_c = t_s10 - 18'(yq_s10) * 18'd365;

	always_ff @(posedge clk) begin
		if (en_s11) begin
			pass_s11 <= pass_s10;
			res_s11  <= res_s10;
			era_s11  <= era_s10;
			doe_s11  <= doe_s10;
			yoe_s11  <= yq_s10 + 9'(ry_c >= 18'd365);
		end
	end

	// Stage 12: day of the March-based year
	gdds_pkg::pass_t pass_s12;
	gdds_pkg::res_t  res_s12;
	logic [4:0]      era_s12;
	logic [8:0]      yoe_s12;
	logic [8:0]      doy_s12;
	logic [1:0]      cent_c;
	logic [17:0]     doy_c;

	assign cent_c = 2'(yoe_s11 >= 9'd100) + 2'(yoe_s11 >= 9'd200) + 2'(yoe_s11 >= 9'd300);
	assign doy_c  = doe_s11 - 18'(yoe_s11) * 18'd365 - 18'(yoe_s11[8:2]) + 18'(cent_c);

	always_ff @(posedge clk) begin
		if (en_s12) begin
			pass_s12 <= pass_s11;
			res_s12  <= res_s11;
			era_s12  <= era_s11;
			yoe_s12  <= yoe_s11;
			doy_s12  <= doy_c[8:0];
		end
	end

	// Stage 13: March-based month, by counting month starts passed
	gdds_pkg::pass_t pass_s13;
	gdds_pkg::res_t  res_s13;
	logic [4:0]      era_s13;
	logic [8:0]      yoe_s13;
	logic [8:0]      doy_s13;
	logic [3:0]      mp_s13;
	logic [3:0]      mp_c;

	always_comb begin
		mp_c = '0;
		for (int k = 1; k < 12; k++) begin
			mp_c = mp_c + 4'(doy_s12 >= gdds_pkg::MONTH_OFFSET[gdds_pkg::mp_to_month(4'(k))]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s13) begin
			pass_s13 <= pass_s12;
			res_s13  <= res_s12;
			era_s13  <= era_s12;
			yoe_s13  <= yoe_s12;
			doy_s13  <= doy_s12;
			mp_s13   <= mp_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 14: final date and the output register. No date, or a year out
	// of range, returns the request date with day number and weekday zero.
	// ------------------------------------------------------------------
	logic [3:0]  mon_c;
	logic [8:0]  dd_c;
	logic [15:0] yr_c;

	assign mon_c = gdds_pkg::mp_to_month(mp_s13);
	assign dd_c  = doy_s13 - gdds_pkg::MONTH_OFFSET[mon_c] + 9'd1;
	// era count includes the extra era added on the way in
	assign yr_c  = 16'(yoe_s13) + 16'(era_s13) * 16'd400 + 16'(mon_c <= 4'd2) - 16'd400;

	always_ff @(posedge clk) begin
		if (en_s14) begin
			present_out <= pass_s13.present;
			if (!pass_s13.present || res_s13.oor) begin
				out_year     <= pass_s13.year;
				out_month    <= pass_s13.month;
				out_day      <= pass_s13.day;
				epoch_day    <= '0;
				weekday      <= '0;
				out_of_range <= pass_s13.present && res_s13.oor;
			end else begin
				out_year     <= yr_c[13:0];
				out_month    <= mon_c;
				out_day      <= dd_c[4:0];
				epoch_day    <= res_s13.dn[22:0];
				weekday      <= res_s13.wd;
				out_of_range <= 1'b0;
			end
		end
	end

endmodule

@@ src/gdds_checker.sv @@
module gdds_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               date_present,
	input logic [13:0]        year,
	input logic [3:0]         month,
	input logic [4:0]         day,
	input logic signed [20:0] day_offset,
	input logic               out_valid,
	input logic               out_stall,
	input logic               present_out,
	input logic [13:0]        out_year,
	input logic [3:0]         out_month,
	input logic [4:0]         out_day,
	input logic signed [22:0] epoch_day,
	input logic [2:0]         weekday,
	input logic               out_of_range
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_year) && $stable(out_month)
			&& $stable(out_day) && $stable(epoch_day) && $stable(weekday)
			&& $stable(out_of_range) && $stable(present_out))
		else $error("stalled result changed");

	// no date: nothing computed, no range flag
	a_no_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !present_out |-> epoch_day == 23'sd0 && weekday == 3'd0 && !out_of_range)
		else $error("pass-through result carries computed fields");

	// out of range only for a present date, with computed fields cleared
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> present_out && epoch_day == 23'sd0 && weekday == 3'd0)
		else $error("out-of-range result malformed");

	// a shifted date is a real calendar date
	a_date_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && present_out && !out_of_range |-> out_year <= 14'd9999
			&& out_month != 4'd0 && out_month <= 4'd12 && out_day != 5'd0
			&& weekday != 3'd7 && epoch_day >= -23'sd719528 && epoch_day <= 23'sd2932896)
		else $error("shifted date out of calendar range");

endmodule

bind gregorian_date_day_shift gdds_checker u_gdds_checker (.*);
